@@ rtl/wcp_pkg.sv @@
// shared types and constants for the weighted channel picker
// no dependencies
package wcp_pkg;
  localparam int unsigned MaxChannelsDef    = 64;
  localparam int unsigned WeightFracBitsDef = 16;
  localparam int unsigned UniformBits       = 16;
  localparam int unsigned CountBits         = 7;
  localparam int unsigned IndexBits         = 6;
  localparam int unsigned StatusBits        = 2;

  typedef enum logic [1:0] {
    ReqWrite   = 2'd0,
    ReqPick    = 2'd1,
    ReqDynPick = 2'd2,
    ReqRescale = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatEmpty    = 2'd1,
    StatZeroTot  = 2'd2,
    StatReserved = 2'd3
  } status_e;
endpackage

@@ rtl/wcp_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module wcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/wcp_divider.sv @@
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module wcp_divider #(
  parameter int unsigned NumBits = 34,
  parameter int unsigned DenBits = 23
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

@@ rtl/weighted_channel_picker.sv @@
// weighted channel picker: top level with the channel table in ram
// depends on wcp_pkg, wcp_ram and wcp_divider
//
// usage: raise start_i with the request fields while busy_o is low; the
// transaction is taken at that edge. exactly one result comes back on
// picked_channel_o, fell_back_o and status_o, marked by done_o for one
// cycle. the receiver cannot stall.
// the table (static weight, dynamic weight, enable) lives in one ram and
// is walked one entry per cycle in sum and scan; the read is registered.
// steps from the accepting edge to done_o, n = channels_in_use capped
// at the table size: a write or an empty table goes straight to done;
// a pick sums the weights of the enabled entries, then scans for the
// target; a dynamic pick that falls back sums again on static weights;
// rescale first sums the static weights, then per entry: a read, a 17x17
// multiply, a divider start, a bit-serial division and the write back.
// one request at a time; a new one can be taken in the done_o cycle.
// reset clears the control state and channels_in_use; the table is
// undefined until written. cfg_we_i may be driven only while idle.
module weighted_channel_picker
  import wcp_pkg::*;
#(
  parameter int unsigned WeightFracBits = WeightFracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CountBits-1:0]        cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  req_type_i,
  input  logic [IndexBits-1:0]        chan_index_i,
  input  logic [WeightFracBits:0]     static_weight_in_i,
  input  logic [WeightFracBits:0]     dynamic_weight_in_i,
  input  logic                        enable_in_i,
  input  logic [UniformBits-1:0]      uniform_i,
  input  logic [WeightFracBits:0]     new_sum_i,
  output logic                        done_o,
  output logic [IndexBits-1:0]        picked_channel_o,
  output logic                        fell_back_o,
  output logic [StatusBits-1:0]       status_o
);
  localparam int unsigned MaxChannels = MaxChannelsDef;
  localparam int unsigned WBits   = WeightFracBits + 1;
  localparam int unsigned AddrW   = $clog2(MaxChannels);
  localparam int unsigned NBits   = $clog2(MaxChannels + 1);
  localparam int unsigned SumBits = WBits + NBits;
  localparam int unsigned ProdW   = WBits + WBits;
  localparam int unsigned EntW    = 2 * WBits + 1;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StSum   = 8'b00000010,
    StScan  = 8'b00000100,
    StRdW   = 8'b00001000,
    StMul   = 8'b00010000,
    StDiv   = 8'b00100000,
    StWb    = 8'b01000000,
    StDone  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [CountBits-1:0]  cfg_q;
  logic [1:0]            req_q, req_d;
  logic                  usedyn_q, usedyn_d, fell_q, fell_d;
  logic [UniformBits-1:0] uni_q, uni_d;
  logic [WBits-1:0]      ns_q, ns_d;
  logic [NBits-1:0]      n_q, n_d, ptr_q, ptr_d;
  logic                  rdv_q, rdv_d;
  logic [SumBits-1:0]    acc_q, acc_d, tgt_q, tgt_d;
  logic [IndexBits-1:0]  pick_q, pick_d;
  logic [StatusBits-1:0] stat_q, stat_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic                  done_q, done_d;
  logic [SumBits+UniformBits-1:0] tprod;

  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [EntW-1:0]   ram_wdata, ram_rdata;
  logic [WBits-1:0]  rd_st, rd_dy, rd_w;
  logic              rd_en;

  logic              div_start, div_done;
  logic [ProdW-1:0]  div_quot;

  assign rd_st = ram_rdata[EntW-1 -: WBits];
  assign rd_dy = ram_rdata[WBits:1];
  assign rd_en = ram_rdata[0];
  assign rd_w  = usedyn_q ? rd_dy : rd_st;

  wcp_ram #(.Width(EntW), .Depth(MaxChannels)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  wcp_divider #(.NumBits(ProdW), .DenBits(SumBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (acc_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign tprod = acc_q * uni_q;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    usedyn_d  = usedyn_q;
    fell_d    = fell_q;
    uni_d     = uni_q;
    ns_d      = ns_q;
    n_d       = n_q;
    ptr_d     = ptr_q;
    rdv_d     = 1'b0;
    acc_d     = acc_q;
    tgt_d     = tgt_q;
    pick_d    = pick_q;
    stat_d    = stat_q;
    prod_d    = prod_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = ptr_q[AddrW-1:0];
    ram_wdata = {rd_st, rd_dy, rd_en};
    div_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d    = req_type_i;
          uni_d    = uniform_i;
          ns_d     = new_sum_i;
          fell_d   = 1'b0;
          pick_d   = '0;
          stat_d   = StatOk;
          acc_d    = '0;
          ptr_d    = '0;
          usedyn_d = (req_type_i == ReqDynPick);
          n_d      = (cfg_q > CountBits'(MaxChannels)) ? NBits'(MaxChannels)
                                                       : NBits'(cfg_q);
          if (req_type_i == ReqWrite) begin
            ram_we    = (32'(chan_index_i) < MaxChannels);
            ram_addr  = AddrW'(chan_index_i);
            ram_wdata = {static_weight_in_i, dynamic_weight_in_i, enable_in_i};
            state_d   = StDone;
          end else if (cfg_q == '0) begin
            stat_d  = StatEmpty;
            state_d = StDone;
          end else begin
            state_d = StSum;
          end
        end
      end
      StSum: begin
        // addresses issue while ptr < n; data lands in the following cycle
        if (ptr_q < n_q) begin
          ptr_d = ptr_q + 1'b1;
          rdv_d = 1'b1;
        end
        if (rdv_q) begin
          if (req_q == ReqRescale) begin
            acc_d = acc_q + SumBits'(rd_st);
          end else if (rd_en) begin
            acc_d = acc_q + SumBits'(rd_w);
          end
        end
        if (!rdv_q && ptr_q == n_q) begin
          ptr_d = '0;
          if (req_q == ReqRescale) begin
            if (acc_q == '0) begin
              stat_d  = StatZeroTot;
              state_d = StDone;
            end else begin
              state_d = StRdW;
            end
          end else if (usedyn_q && acc_q == '0) begin
            usedyn_d = 1'b0;
            fell_d   = 1'b1;
          end else begin
            tgt_d = SumBits'(tprod >> UniformBits);
            if ((tprod >> UniformBits) == '0) begin
              state_d = StDone;
            end else begin
              acc_d   = '0;
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        if (ptr_q < n_q) begin
          ptr_d = ptr_q + 1'b1;
          rdv_d = 1'b1;
        end
        if (rdv_q && rd_en) begin
          acc_d = acc_q + SumBits'(rd_w);
          if (acc_q + SumBits'(rd_w) >= tgt_q) begin
            pick_d  = IndexBits'(ptr_q - 1'b1);
            state_d = StDone;
          end
        end
        if (!rdv_q && ptr_q == n_q) begin
          state_d = StDone;
        end
      end
      StRdW: begin
        if (ptr_q == n_q) begin
          state_d = StDone;
        end else begin
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = rd_st * ns_q;
        state_d = StDiv;
      end
      StDiv: begin
        div_start = 1'b1;
        state_d   = StWb;
      end
      StWb: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_wdata = {div_quot[WBits-1:0], rd_dy, rd_en};
          ptr_d     = ptr_q + 1'b1;
          state_d   = StRdW;
        end
      end
      StDone: begin
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q   <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    usedyn_q <= usedyn_d;
    fell_q   <= fell_d;
    uni_q    <= uni_d;
    ns_q     <= ns_d;
    n_q      <= n_d;
    ptr_q    <= ptr_d;
    acc_q    <= acc_d;
    tgt_q    <= tgt_d;
    pick_q   <= pick_d;
    stat_q   <= stat_d;
    prod_q   <= prod_d;
  end

  assign busy_o           = (state_q != StIdle);
  assign done_o           = done_q;
  assign picked_channel_o = done_q ? pick_q : '0;
  assign fell_back_o      = done_q & fell_q;
  assign status_o         = done_q ? stat_q : '0;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_fell_dyn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fell_back_o |-> (req_q == ReqDynPick)) else $error("fallback on wrong request");
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == ReqWrite) |=> ##1 done_o)
    else $error("write result late");
endmodule
